[rtl/rbc_pkg.sv]
// Shared types, constants and helper functions for the radix base converter.
package rbc_pkg;

	localparam int CHAR_W        = 8;
	localparam int BASE_W        = 6;
	localparam int STACK_DEPTH   = 32;
	localparam int STACK_AW      = $clog2(STACK_DEPTH);
	localparam int COUNT_W       = STACK_AW + 1;
	localparam int BITS_PER_STEP = 4;
	localparam int CFG_INDEX_W   = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_IN_BASE  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_BASE = CFG_INDEX_W'(1);

	localparam logic [BASE_W-1:0] BASE_MIN       = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX       = BASE_W'(36);
	localparam logic [BASE_W-1:0] IN_BASE_RESET  = BASE_W'(10);
	localparam logic [BASE_W-1:0] OUT_BASE_RESET = BASE_W'(2);

	localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] ASCII_NINE   = CHAR_W'(57);
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = CHAR_W'(65);
	localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = CHAR_W'(90);
	localparam logic [CHAR_W-1:0] LETTER_OFFSET = CHAR_W'(55);
	localparam logic [CHAR_W-1:0] BAD_DIGIT    = CHAR_W'(255);
	localparam logic [BASE_W-1:0] FIRST_LETTER = BASE_W'(10);

	// controller -> datapath
	typedef struct packed {
		logic take_item;
		logic mac;
		logic div_load;
		logic div_restart;
		logic div_step;
		logic push;
		logic pop;
		logic load_digit;
		logic load_err;
		logic clear_run;
	} rbc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic last_item;
		logic div_last;
		logic quot_zero;
		logic stack_full;
		logic count_zero;
		logic out_free;
	} rbc_status_t;

	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b < BASE_MIN) begin
			r = BASE_MIN;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	// digit value, or BAD_DIGIT for anything that is not '0'-'9' / 'A'-'Z'
	function automatic logic [CHAR_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			r = c - ASCII_ZERO;
		end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c - LETTER_OFFSET;
		end else begin
			r = BAD_DIGIT;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] encode_digit(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d >= FIRST_LETTER) begin
			r = CHAR_W'(d) + LETTER_OFFSET;
		end else begin
			r = CHAR_W'(d) + ASCII_ZERO;
		end
		return r;
	endfunction

endpackage

[rtl/radix_base_converter_top.sv]
// Top level of the radix base converter: controller, datapath and checks.
// Radix base converter. Digit characters ('0'-'9', 'A'-'Z') enter one beat at
// a time, most significant first, in the radix held in in_base; the beat with
// last_char set closes the number. The block then emits the value in the
// radix held in out_base as ASCII digits, most significant first, one output
// beat per digit, with last_digit on the final one. A character that is not a
// digit of in_base, or a value that does not fit in VALUE_WIDTH bits, turns
// the whole run into one beat with error=1, digit_code=0 and last_digit=1; a
// run that would need more than 32 output digits ends the same way. Base
// registers are clamped to 2..36 when used, and may only be written while the
// block is idle (cfg_ready is always high). Each input beat is captured, then
// goes through one multiply-accumulate. After the last character, the divider
// works out each output digit in turn, retiring 4 quotient bits per cycle, and
// pushes it onto the digit stack; each digit is then popped from the digit
// stack RAM (registered read) into the output register, a pop waiting while
// the output register holds a stalled beat. The input side reopens once the
// final result is in the output register, so the next number can start while
// that beat still waits to be taken.
module radix_base_converter_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input digit characters
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rbc_pkg::CHAR_W-1:0]      char_code,
	input  logic                            last_char,
	// output digit characters
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rbc_pkg::CHAR_W-1:0]      digit_code,
	output logic                            last_digit,
	output logic                            error,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbc_pkg::BASE_W-1:0]      cfg_data
);

	rbc_pkg::rbc_cmd_t    cmd;
	rbc_pkg::rbc_status_t st;

	// writes are only legal while idle, so no back-pressure is needed
	assign cfg_ready = 1'b1;

	rbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rbc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_code (digit_code),
		.last_digit (last_digit),
		.error      (error)
	);

	// the divider never runs on a full digit stack
	a_no_div_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !st.stack_full)
		else $error("divider stepping with a full digit stack");

	// a digit is only moved into an empty output register
	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_digit |-> !out_valid)
		else $error("output register overwritten");

	// pops never underflow the stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !st.count_zero)
		else $error("pop from an empty digit stack");

	// an accepted character always keeps the input closed for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input reopened before accumulate step");

endmodule

[rtl/rbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rbc_datapath.sv]
// Datapath: base registers, accumulator, digit divider, digit stack and output register.
module rbc_datapath #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rbc_pkg::rbc_cmd_t                   cmd,
	output rbc_pkg::rbc_status_t                st,
	input  logic                                cfg_we,
	input  logic [rbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rbc_pkg::BASE_W-1:0]          cfg_data,
	input  logic [rbc_pkg::CHAR_W-1:0]          char_code,
	input  logic                                last_char,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rbc_pkg::CHAR_W-1:0]          digit_code,
	output logic                                last_digit,
	output logic                                error
);

	localparam int BW    = rbc_pkg::BASE_W;
	localparam int BPS   = rbc_pkg::BITS_PER_STEP;
	localparam int STEPS = (VALUE_WIDTH + BPS - 1) / BPS;
	localparam int PW    = STEPS * BPS;
	localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int MW    = VALUE_WIDTH + BW;

	logic [BW-1:0]                   in_base_q, out_base_q;
	logic [BW-1:0]                   ib, ob;
	logic [rbc_pkg::CHAR_W-1:0]      char_q;
	logic                            last_q;
	logic [VALUE_WIDTH-1:0]          acc_q;
	logic                            err_q;
	logic [PW-1:0]                   div_q;
	logic [BW-1:0]                   rem_q;
	logic [SCW-1:0]                  step_q;
	logic [rbc_pkg::COUNT_W-1:0]     count_q;
	logic                            out_valid_q;
	logic [rbc_pkg::CHAR_W-1:0]      digit_q;
	logic                            last_digit_q;
	logic                            error_q;

	logic [rbc_pkg::CHAR_W-1:0]      dval;
	logic [MW-1:0]                   prod;
	logic                            ovf;
	logic [PW-1:0]                   div_nxt;
	logic [BW-1:0]                   rem_nxt;
	logic [BW-1:0]                   rd_digit;
	logic [rbc_pkg::COUNT_W-1:0]     count_dec;

	assign ib = rbc_pkg::clamp_base(in_base_q);
	assign ob = rbc_pkg::clamp_base(out_base_q);

	// multiply-accumulate; anything above VALUE_WIDTH is an overflow
	assign dval = rbc_pkg::decode_char(char_q);
	assign prod = MW'(acc_q) * MW'(ib) + MW'(dval);
	assign ovf  = |prod[MW-1:VALUE_WIDTH];

	// long division by ob, BPS quotient bits per cycle
	always_comb begin
		logic [BW:0]     t;
		logic [BW-1:0]   r;
		logic [BPS-1:0]  qb;
		logic [BPS-1:0]  top;
		top = div_q[PW-1 -: BPS];
		r   = rem_q;
		qb  = '0;
		for (int i = BPS - 1; i >= 0; i--) begin
			t = {r, top[i]};
			if (t >= {1'b0, ob}) begin
				t     = t - {1'b0, ob};
				qb[i] = 1'b1;
			end
			r = t[BW-1:0];
		end
		rem_nxt = r;
		if (PW > BPS) begin
			div_nxt = {div_q[PW-BPS-1:0], qb};
		end else begin
			div_nxt = PW'(qb);
		end
	end

	assign count_dec = count_q - rbc_pkg::COUNT_W'(1);

	rbc_ram #(
		.WIDTH (BW),
		.DEPTH (rbc_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (count_q[rbc_pkg::STACK_AW-1:0]),
		.wdata (rem_nxt),
		.raddr (count_dec[rbc_pkg::STACK_AW-1:0]),
		.rdata (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q   <= rbc_pkg::IN_BASE_RESET;
			out_base_q  <= rbc_pkg::OUT_BASE_RESET;
			acc_q       <= '0;
			err_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == rbc_pkg::REG_IN_BASE) begin
				in_base_q <= cfg_data;
			end
			if (cfg_we && cfg_index == rbc_pkg::REG_OUT_BASE) begin
				out_base_q <= cfg_data;
			end
			if (cmd.mac && !err_q) begin
				if (dval >= rbc_pkg::CHAR_W'(ib) || ovf) begin
					err_q <= 1'b1;
				end else begin
					acc_q <= prod[VALUE_WIDTH-1:0];
				end
			end
			if (cmd.push) begin
				count_q <= count_q + rbc_pkg::COUNT_W'(1);
			end
			if (cmd.pop) begin
				count_q <= count_dec;
			end
			if (cmd.clear_run) begin
				acc_q   <= '0;
				err_q   <= 1'b0;
				count_q <= '0;
			end
			if (cmd.load_digit || cmd.load_err) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			char_q <= char_code;
			last_q <= last_char;
		end
		if (cmd.div_load) begin
			div_q  <= PW'(acc_q);
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_restart) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			div_q  <= div_nxt;
			rem_q  <= rem_nxt;
			step_q <= step_q + SCW'(1);
		end
		if (cmd.load_digit) begin
			digit_q      <= rbc_pkg::encode_digit(rd_digit);
			last_digit_q <= (count_q == '0);
			error_q      <= 1'b0;
		end else if (cmd.load_err) begin
			digit_q      <= '0;
			last_digit_q <= 1'b1;
			error_q      <= 1'b1;
		end
	end

	assign st.err        = err_q;
	assign st.last_item  = last_q;
	assign st.div_last   = (step_q == SCW'(STEPS - 1));
	assign st.quot_zero  = (div_q == '0);
	assign st.stack_full = (count_q == rbc_pkg::COUNT_W'(rbc_pkg::STACK_DEPTH));
	assign st.count_zero = (count_q == '0);
	assign st.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign digit_code = digit_q;
	assign last_digit = last_digit_q;
	assign error      = error_q;

endmodule

[rtl/rbc_ctrl.sv]
// Controller: sequences accumulate, divide, push and pop steps of one run.
module rbc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rbc_pkg::rbc_status_t st,
	output rbc_pkg::rbc_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_CHK,
		S_DIV,
		S_NEXT,
		S_ERR,
		S_POP,
		S_LOAD
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_ACC;
				end
			end
			S_ACC: begin
				cmd.mac = 1'b1;
				state_d = st.last_item ? S_CHK : S_IDLE;
			end
			S_CHK: begin
				if (st.err) begin
					state_d = S_ERR;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					cmd.push = 1'b1;
					state_d  = S_NEXT;
				end
			end
			S_NEXT: begin
				if (st.quot_zero) begin
					state_d = S_POP;
				end else if (st.stack_full) begin
					state_d = S_ERR;
				end else begin
					cmd.div_restart = 1'b1;
					state_d         = S_DIV;
				end
			end
			S_ERR: begin
				if (st.out_free) begin
					cmd.load_err  = 1'b1;
					cmd.clear_run = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_POP: begin
				if (st.out_free) begin
					cmd.pop = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_digit = 1'b1;
				if (st.count_zero) begin
					cmd.clear_run = 1'b1;
					state_d       = S_IDLE;
				end else begin
					state_d = S_POP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
